// ----- hw/rtl/pbrp_pkg.sv -----
// Shared types, codes and constants for the settings blob record parser.
package pbrp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_NUMERIC = 2'd2;
    localparam logic [1:0] KIND_VERDICT = 2'd3;

    // Record types
    localparam logic [1:0] TYPE_INT    = 2'd0;
    localparam logic [1:0] TYPE_FLOAT  = 2'd1;
    localparam logic [1:0] TYPE_STRING = 2'd2;

    // Header layout
    localparam logic [3:0]  HPOS_MAGIC_END = 4'd4;
    localparam logic [3:0]  HPOS_VERSION   = 4'd7;
    localparam logic [3:0]  HPOS_COUNT     = 4'd11;
    localparam logic [31:0] PREFS_VERSION  = 32'd1;
    localparam logic [15:0] NUMERIC_LEN    = 16'd4;
    localparam int unsigned NUMERIC_LAST   = 3;

    // Parameter defaults
    localparam int unsigned DEF_MAX_ENTRIES       = 32;
    localparam int unsigned DEF_MAX_KEY_LENGTH    = 32;
    localparam int unsigned DEF_MAX_STRING_LENGTH = 64;

    // Result queue depth (power of two)
    localparam int unsigned RES_DEPTH = 4;

    // Output stream widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_TUSER_W = 2;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  entry_index;
        logic [5:0]  byte_offset;
        logic [7:0]  byte_value;
        logic [1:0]  entry_type;
        logic [4:0]  key_length;
        logic [5:0]  value_length;
        logic [31:0] numeric_value;
        logic [5:0]  entry_count;
        logic        accepted;
        logic        last_result;
    } t_result;

    // Magic byte at header positions 0..3: 'P' '2' 'P' 'F'
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h50;
            2'd1: b = 8'h32;
            2'd2: b = 8'h50;
            2'd3: b = 8'h46;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/pbrp_parser.sv -----
// Byte-wise header and record parser: state registers and result generation.
module pbrp_parser
    import pbrp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES       = DEF_MAX_ENTRIES,
    parameter int unsigned MAX_KEY_LENGTH    = DEF_MAX_KEY_LENGTH,
    parameter int unsigned MAX_STRING_LENGTH = DEF_MAX_STRING_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic [1:0] o_res_cnt,
    output t_result    o_res0,
    output t_result    o_res1
);

    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned LEN_MX = (MAX_KEY_LENGTH > MAX_STRING_LENGTH) ?
                                     MAX_KEY_LENGTH : MAX_STRING_LENGTH;
    localparam int unsigned FP_MX  = (LEN_MX > 4) ? LEN_MX : 4;
    localparam int unsigned FP_W   = $clog2(FP_MX);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_RECHDR,
        PH_KEY,
        PH_VALUE,
        PH_DONE
    } t_phase;

    t_phase           r_phase,    n_phase;
    logic [3:0]       r_hpos,     n_hpos;
    logic [31:0]      r_word,     n_word;
    logic [CNT_W-1:0] r_expected, n_expected;
    logic [CNT_W-1:0] r_recnum,   n_recnum;
    logic [1:0]       r_type,     n_type;
    logic [7:0]       r_klen,     n_klen;
    logic [15:0]      r_vlen,     n_vlen;
    logic [FP_W-1:0]  r_fp,       n_fp;
    logic             r_rejected, n_rejected;

    logic [31:0]      word_sh;
    logic [FP_W-1:0]  fp_inc;
    logic [CNT_W-1:0] rec_inc;
    logic [15:0]      vlen_full;
    logic [31:0]      rec_ext;
    logic [31:0]      exp_ext;
    logic [31:0]      fp_ext;
    logic             pay_v;
    logic             ok;
    t_result          pay;
    t_result          verdict;

    assign word_sh   = {i_byte, r_word[31:8]};
    assign fp_inc    = r_fp + 1'b1;
    assign rec_inc   = r_recnum + 1'b1;
    assign vlen_full = {i_byte, r_vlen[7:0]};
    assign rec_ext   = 32'(r_recnum);
    assign exp_ext   = 32'(r_expected);
    assign fp_ext    = 32'(r_fp);

    // Next state and results for the byte being accepted
    always_comb begin
        n_phase    = r_phase;
        n_hpos     = r_hpos;
        n_word     = r_word;
        n_expected = r_expected;
        n_recnum   = r_recnum;
        n_type     = r_type;
        n_klen     = r_klen;
        n_vlen     = r_vlen;
        n_fp       = r_fp;
        n_rejected = r_rejected;
        pay_v      = 1'b0;

        // payload fields common to all payload kinds
        pay               = '0;
        pay.entry_index   = rec_ext[4:0];
        pay.entry_type    = r_type;
        pay.key_length    = r_klen[4:0];
        pay.value_length  = r_vlen[5:0];
        pay.byte_offset   = fp_ext[5:0];
        pay.byte_value    = i_byte;

        verdict      = '0;
        verdict.kind = KIND_VERDICT;
        ok           = 1'b0;
        o_res_cnt    = 2'd0;
        o_res0       = '0;
        o_res1       = '0;

        if (i_valid) begin
            if (!r_rejected) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_word = word_sh;
                        if (r_hpos < HPOS_MAGIC_END) begin
                            if (i_byte != magic_byte(r_hpos[1:0])) n_rejected = 1'b1;
                        end else if (r_hpos == HPOS_VERSION) begin
                            if (word_sh != PREFS_VERSION) n_rejected = 1'b1;
                        end else if (r_hpos == HPOS_COUNT) begin
                            if (word_sh > 32'(MAX_ENTRIES)) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_expected = word_sh[CNT_W-1:0];
                                n_recnum   = '0;
                                n_fp       = '0;
                                n_phase    = (word_sh == 32'd0) ? PH_DONE : PH_RECHDR;
                            end
                        end
                        n_hpos = r_hpos + 1'b1;
                    end
                    PH_RECHDR: begin
                        priority if (fp_ext == 32'd0) begin
                            if (i_byte > 8'(TYPE_STRING)) n_rejected = 1'b1;
                            n_type = i_byte[1:0];
                        end else if (fp_ext == 32'd1) begin
                            if (i_byte == 8'd0 || 32'(i_byte) >= 32'(MAX_KEY_LENGTH))
                                n_rejected = 1'b1;
                            n_klen = i_byte;
                        end else if (fp_ext == 32'd2) begin
                            n_vlen = 16'(i_byte);
                        end else begin
                            n_vlen = vlen_full;
                            if (r_type == TYPE_STRING) begin
                                if (32'(vlen_full) >= 32'(MAX_STRING_LENGTH))
                                    n_rejected = 1'b1;
                            end else if (vlen_full != NUMERIC_LEN) begin
                                n_rejected = 1'b1;
                            end
                        end
                        if (fp_ext >= 32'd3) begin
                            n_fp    = '0;
                            n_phase = PH_KEY;
                        end else begin
                            n_fp = fp_inc;
                        end
                    end
                    PH_KEY: begin
                        pay_v    = 1'b1;
                        pay.kind = KIND_KEY;
                        if (32'(fp_inc) >= 32'(r_klen)) begin
                            n_fp   = '0;
                            n_word = '0;
                            if (r_vlen == 16'd0) begin
                                n_recnum = rec_inc;
                                n_phase  = (rec_inc >= r_expected) ? PH_DONE : PH_RECHDR;
                            end else begin
                                n_phase = PH_VALUE;
                            end
                        end else begin
                            n_fp = fp_inc;
                        end
                    end
                    PH_VALUE: begin
                        if (r_type == TYPE_STRING) begin
                            pay_v    = 1'b1;
                            pay.kind = KIND_STRING;
                        end else begin
                            n_word = word_sh;
                            if (fp_ext == 32'(NUMERIC_LAST)) begin
                                pay_v             = 1'b1;
                                pay.kind          = KIND_NUMERIC;
                                pay.byte_offset   = '0;
                                pay.byte_value    = '0;
                                pay.numeric_value = word_sh;
                            end
                        end
                        if (32'(fp_inc) >= 32'(r_vlen)) begin
                            n_fp     = '0;
                            n_recnum = rec_inc;
                            n_phase  = (rec_inc >= r_expected) ? PH_DONE : PH_RECHDR;
                        end else begin
                            n_fp = fp_inc;
                        end
                    end
                    PH_DONE: begin
                        // trailing bytes are ignored
                    end
                    default: begin
                    end
                endcase
            end

            // a rejection on this byte suppresses any payload
            if (n_rejected) pay_v = 1'b0;

            // verdict at the flagged byte
            ok = !n_rejected && (n_phase == PH_DONE);
            verdict.entry_count = ok ? exp_ext[5:0] : 6'd0;
            if (ok && r_phase == PH_HEADER) begin
                verdict.entry_count = word_sh[5:0];
            end
            verdict.accepted    = ok;
            verdict.last_result = 1'b1;

            if (pay_v && i_last) begin
                o_res_cnt = 2'd2;
                o_res0    = pay;
                o_res1    = verdict;
            end else if (pay_v) begin
                o_res_cnt          = 2'd1;
                o_res0             = pay;
                o_res0.last_result = 1'b1;
            end else if (i_last) begin
                o_res_cnt = 2'd1;
                o_res0    = verdict;
            end

            // a verdict returns everything to the start of a new blob
            if (i_last) begin
                n_phase    = PH_HEADER;
                n_hpos     = '0;
                n_word     = '0;
                n_expected = '0;
                n_recnum   = '0;
                n_type     = '0;
                n_klen     = '0;
                n_vlen     = '0;
                n_fp       = '0;
                n_rejected = 1'b0;
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hpos     <= '0;
            r_word     <= '0;
            r_expected <= '0;
            r_recnum   <= '0;
            r_type     <= '0;
            r_klen     <= '0;
            r_vlen     <= '0;
            r_fp       <= '0;
            r_rejected <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hpos     <= n_hpos;
            r_word     <= n_word;
            r_expected <= n_expected;
            r_recnum   <= n_recnum;
            r_type     <= n_type;
            r_klen     <= n_klen;
            r_vlen     <= n_vlen;
            r_fp       <= n_fp;
            r_rejected <= n_rejected;
        end
    end

endmodule

// ----- hw/rtl/pbrp_fifo.sv -----
// Small result queue: takes up to two results per cycle, hands out one per cycle when popped.
module pbrp_fifo
    import pbrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    input  logic       i_pop,
    output logic       o_valid,
    output logic       o_space2,
    output t_result    o_head
);

    localparam int unsigned PTR_W = $clog2(RES_DEPTH);

    t_result          r_mem [RES_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count,  n_count;
    logic             pop_en;
    logic [PTR_W-1:0] wr_ptr1;

    assign o_valid  = (r_count != '0);
    assign o_space2 = (32'(r_count) <= RES_DEPTH - 2);
    assign o_head   = r_mem[r_rd_ptr];
    assign pop_en   = i_pop && o_valid;
    assign wr_ptr1  = r_wr_ptr + 1'b1;

    // Pointer and level updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_cnt);
        n_rd_ptr = pop_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PTR_W + 1)'(i_push_cnt) - (PTR_W + 1)'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wr_ptr] <= i_res0;
        if (i_push_cnt == 2'd2) r_mem[wr_ptr1]  <= i_res1;
    end

endmodule

// ----- hw/rtl/prefs_blob_record_parser.sv -----
// Top level of the settings blob record parser: byte stream in, result stream out.
//
//  channel | dir | tdata                          | tuser | tlast
//  s_axis  | in  | data_byte                      | -     | last_byte
//  m_axis  | out | entry_index .. accepted (72b)  | kind  | last_result
//
// One byte is accepted per cycle while tready is high; its results are registered into
// the result queue. A byte that both finishes a payload and carries the last flag yields
// two results, drained one per cycle while m_axis_tready is high from a four-entry result
// queue; tready drops while fewer than two queue entries are free. Reset is synchronous
// and active low. Output stalls backpressure the input only through that queue.
module prefs_blob_record_parser
    import pbrp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES       = DEF_MAX_ENTRIES,
    parameter int unsigned MAX_KEY_LENGTH    = DEF_MAX_KEY_LENGTH,
    parameter int unsigned MAX_STRING_LENGTH = DEF_MAX_STRING_LENGTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic                   s_axis_tlast,  // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [4:0] entry_index, [10:5] byte_offset, [18:11] byte_value, [20:19] entry_type,
    // [25:21] key_length, [31:26] value_length, [63:32] numeric_value,
    // [69:64] entry_count, [70] accepted, [71] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [1:0] kind
    output logic                   m_axis_tlast   // last_result
);

    logic       in_req;
    logic [1:0] res_cnt;
    t_result    res0;
    t_result    res1;
    t_result    head;
    logic       space2;

    assign s_axis_tready = space2;
    assign in_req        = s_axis_tvalid && s_axis_tready;

    // Parser
    pbrp_parser #(
        .MAX_ENTRIES       (MAX_ENTRIES),
        .MAX_KEY_LENGTH    (MAX_KEY_LENGTH),
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_req),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_res_cnt (res_cnt),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    // Result queue
    pbrp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (res_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_space2   (space2),
        .o_head     (head)
    );

    // Output packing
    assign m_axis_tdata = {1'b0, head.accepted, head.entry_count, head.numeric_value,
                           head.value_length, head.key_length, head.entry_type,
                           head.byte_value, head.byte_offset, head.entry_index};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_result;

`ifndef SYNTHESIS
    // a verdict is always the final result of its byte
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_VERDICT) |-> m_axis_tlast)
        else $error("verdict without last_result");

    // a flagged byte always leaves a result queued
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_req && s_axis_tlast) |=> m_axis_tvalid)
        else $error("flagged byte produced no result");

    // a rejecting verdict carries no entry count
    a_reject_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_VERDICT && !m_axis_tdata[70])
        |-> (m_axis_tdata[69:64] == 6'd0))
        else $error("reject verdict with nonzero entry count");
`endif

endmodule

// ----- tb/prefs_blob_record_parser_tb.sv -----
// Testbench for the settings blob record parser: random blobs, flaws and stream stalls.
`timescale 1ns / 1ps

module prefs_blob_record_parser_tb;
    import pbrp_pkg::*;

    // Run control
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PRINT_LIMIT    = 40;

    // Magic bytes 'P' '2' 'P' 'F', first byte in the low bits
    localparam logic [31:0] MAGIC_WORD = 32'h4650_3250;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        P_HEADER,
        P_REC_HDR,
        P_KEY,
        P_VALUE,
        P_DONE
    } parse_phase_e;

    // Ways a generated blob can be broken
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_COUNT,
        FLAW_TYPE,
        FLAW_KEY_LEN,
        FLAW_VALUE_LEN
    } blob_flaw_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [4:0] entry_index, [10:5] byte_offset, [18:11] byte_value, [20:19] entry_type,
    // [25:21] key_length, [31:26] value_length, [63:32] numeric_value,
    // [69:64] entry_count, [70] accepted, [71] zero
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;           // last_result

    prefs_blob_record_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial forever #4 i_clk = ~i_clk;

    // Predicted results waiting for the output, oldest first
    t_result     due_results[$];
    // Bytes of the blob being sent
    logic [7:0]  blob_bytes[$];

    // Predictor state
    parse_phase_e ph;
    logic [3:0]   hdr_pos;
    logic [31:0]  word_acc;
    logic [5:0]   n_declared;
    logic [5:0]   rec_num;
    logic [1:0]   rec_type;
    logic [7:0]   rec_klen;
    logic [15:0]  rec_vlen;
    logic [15:0]  field_pos;
    logic         blob_bad;

    // Bookkeeping
    int  error_count = 0;
    int  results_checked = 0;
    int  bytes_sent = 0;
    int  blobs_sent = 0;
    int  blobs_accepted = 0;
    int  blobs_rejected = 0;
    int  quiet_cycles = 0;
    int  rx_wait = 0;
    bit  tx_idle = 1'b0;
    bit  rx_idle = 1'b0;

    function automatic void clear_parse_state();
        ph         = P_HEADER;
        hdr_pos    = '0;
        word_acc   = '0;
        n_declared = '0;
        rec_num    = '0;
        rec_type   = '0;
        rec_klen   = '0;
        rec_vlen   = '0;
        field_pos  = '0;
        blob_bad   = 1'b0;
    endfunction

    function automatic t_result payload_result(input logic [1:0] k, input logic [5:0] off,
                                               input logic [7:0] b, input logic [31:0] num);
        t_result r;
        r               = '0;
        r.kind          = k;
        r.entry_index   = rec_num[4:0];
        r.byte_offset   = off;
        r.byte_value    = b;
        r.entry_type    = rec_type;
        r.key_length    = rec_klen[4:0];
        r.value_length  = rec_vlen[5:0];
        r.numeric_value = num;
        return r;
    endfunction

    function automatic void finish_record();
        rec_num   = rec_num + 1'b1;
        field_pos = '0;
        ph        = (rec_num >= n_declared) ? P_DONE : P_REC_HDR;
    endfunction

    // Advance the parser by one byte and queue the results it causes
    function automatic void parse_blob_byte(input logic [7:0] b, input logic l);
        t_result r;
        t_result v;
        bit      have;
        bit      ok;
        have = 1'b0;
        r    = '0;
        if (!blob_bad) begin
            case (ph)
                P_HEADER: begin
                    word_acc = {b, word_acc[31:8]};
                    if (hdr_pos < HPOS_MAGIC_END) begin
                        if (b != MAGIC_WORD[8*hdr_pos[1:0] +: 8])
                            blob_bad = 1'b1;
                    end else if (hdr_pos == HPOS_VERSION) begin
                        if (word_acc != PREFS_VERSION)
                            blob_bad = 1'b1;
                    end else if (hdr_pos == HPOS_COUNT) begin
                        if (word_acc > DEF_MAX_ENTRIES) begin
                            blob_bad = 1'b1;
                        end else begin
                            n_declared = word_acc[5:0];
                            rec_num    = '0;
                            field_pos  = '0;
                            ph         = (word_acc == 0) ? P_DONE : P_REC_HDR;
                        end
                    end
                    hdr_pos = hdr_pos + 1'b1;
                end
                P_REC_HDR: begin
                    if (field_pos == 0) begin
                        if (b > TYPE_STRING)
                            blob_bad = 1'b1;
                        rec_type = b[1:0];
                    end else if (field_pos == 1) begin
                        if (b == 0 || b >= DEF_MAX_KEY_LENGTH)
                            blob_bad = 1'b1;
                        rec_klen = b;
                    end else if (field_pos == 2) begin
                        rec_vlen = {8'h00, b};
                    end else begin
                        rec_vlen = {b, rec_vlen[7:0]};
                        if (rec_type == TYPE_STRING) begin
                            if (rec_vlen >= DEF_MAX_STRING_LENGTH)
                                blob_bad = 1'b1;
                        end else if (rec_vlen != NUMERIC_LEN) begin
                            blob_bad = 1'b1;
                        end
                    end
                    if (field_pos >= 3) begin
                        field_pos = '0;
                        ph        = P_KEY;
                    end else begin
                        field_pos = field_pos + 1'b1;
                    end
                end
                P_KEY: begin
                    r    = payload_result(KIND_KEY, field_pos[5:0], b, 32'h0);
                    have = 1'b1;
                    field_pos = field_pos + 1'b1;
                    if (field_pos >= rec_klen) begin
                        field_pos = '0;
                        word_acc  = '0;
                        if (rec_vlen == 0)
                            finish_record();
                        else
                            ph = P_VALUE;
                    end
                end
                P_VALUE: begin
                    if (rec_type == TYPE_STRING) begin
                        r    = payload_result(KIND_STRING, field_pos[5:0], b, 32'h0);
                        have = 1'b1;
                    end else begin
                        word_acc = {b, word_acc[31:8]};
                        if (field_pos == NUMERIC_LAST) begin
                            r    = payload_result(KIND_NUMERIC, 6'd0, 8'h00, word_acc);
                            have = 1'b1;
                        end
                    end
                    field_pos = field_pos + 1'b1;
                    if (field_pos >= rec_vlen)
                        finish_record();
                end
                default: ;
            endcase
        end
        if (blob_bad)
            have = 1'b0;

        if (have) begin
            r.last_result = !l;
            due_results.push_back(r);
        end
        // Verdict closes the blob and restarts the parser
        if (l) begin
            ok             = !blob_bad && ph == P_DONE;
            v              = '0;
            v.kind         = KIND_VERDICT;
            v.entry_count  = ok ? n_declared : 6'd0;
            v.accepted     = ok;
            v.last_result  = 1'b1;
            due_results.push_back(v);
            if (ok)
                blobs_accepted++;
            else
                blobs_rejected++;
            clear_parse_state();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ERROR result %0d: %s got 0x%0h want 0x%0h",
                     $time, results_checked, what, got, want);
    endtask

    // Compare one output result against the oldest prediction
    task automatic check_result();
        t_result got;
        t_result want;
        got.kind          = m_axis_tuser;
        got.entry_index   = m_axis_tdata[4:0];
        got.byte_offset   = m_axis_tdata[10:5];
        got.byte_value    = m_axis_tdata[18:11];
        got.entry_type    = m_axis_tdata[20:19];
        got.key_length    = m_axis_tdata[25:21];
        got.value_length  = m_axis_tdata[31:26];
        got.numeric_value = m_axis_tdata[63:32];
        got.entry_count   = m_axis_tdata[69:64];
        got.accepted      = m_axis_tdata[70];
        got.last_result   = m_axis_tlast;
        results_checked++;
        rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
        if (m_axis_tdata[71] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[71], 0);
        if (due_results.size() == 0) begin
            report_mismatch("unexpected result, kind", got.kind, 0);
        end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", got.kind, want.kind);
            if (got.entry_index !== want.entry_index)
                report_mismatch("entry_index", got.entry_index, want.entry_index);
            if (got.byte_offset !== want.byte_offset)
                report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
            if (got.byte_value !== want.byte_value)
                report_mismatch("byte_value", got.byte_value, want.byte_value);
            if (got.entry_type !== want.entry_type)
                report_mismatch("entry_type", got.entry_type, want.entry_type);
            if (got.key_length !== want.key_length)
                report_mismatch("key_length", got.key_length, want.key_length);
            if (got.value_length !== want.value_length)
                report_mismatch("value_length", got.value_length, want.value_length);
            if (got.numeric_value !== want.numeric_value)
                report_mismatch("numeric_value", got.numeric_value, want.numeric_value);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", got.entry_count, want.entry_count);
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", got.accepted, want.accepted);
            if (got.last_result !== want.last_result)
                report_mismatch("last_result", got.last_result, want.last_result);
        end
    endtask

    // Output side: sample at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    // Output side: per-result stall drawn by the checker
    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, due_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Send one byte request, with a random gap before it when idling is on
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_blob_byte(b, l);
        bytes_sent++;
    endtask

    // Stop sending and let every predicted result drain
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_blob();
        int i;
        for (i = 0; i < blob_bytes.size(); i++)
            send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
        blobs_sent++;
    endtask

    function automatic void put_word(input logic [31:0] w);
        int i;
        for (i = 0; i < 4; i++)
            blob_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_header(input logic [31:0] count, input blob_flaw_e flaw);
        logic [31:0] magic;
        logic [31:0] version;
        int          idx;
        magic   = MAGIC_WORD;
        version = PREFS_VERSION;
        idx     = $urandom_range(0, 3);
        if (flaw == FLAW_MAGIC)
            magic[8*idx +: 8] = magic[8*idx +: 8] ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_VERSION)
            version = version ^ (32'h1 << $urandom_range(0, 31));
        // Count one over the limit, larger in the low byte, or a high byte set
        if (flaw == FLAW_COUNT) begin
            case ($urandom_range(0, 2))
                0:       count = DEF_MAX_ENTRIES + 1;
                1:       count = $urandom_range(DEF_MAX_ENTRIES + 1, 255);
                default: count = count | (32'h1 << $urandom_range(8, 31));
            endcase
        end
        put_word(magic);
        put_word(version);
        put_word(count);
    endfunction

    // One record with random type, lengths and content; sizes pick the max now and then
    function automatic void put_record(input blob_flaw_e flaw, input int klen_max,
                                       input int vlen_max);
        logic [7:0]  typ;
        logic [7:0]  klen;
        logic [15:0] vlen;
        int          kbytes;
        int          vbytes;
        int          i;
        typ  = 8'($urandom_range(0, 2));
        klen = ($urandom_range(0, 3) == 0) ? 8'(klen_max) : 8'($urandom_range(1, klen_max));
        if (typ == TYPE_STRING)
            vlen = ($urandom_range(0, 3) == 0) ? 16'(vlen_max) :
                                                 16'($urandom_range(0, vlen_max));
        else
            vlen = NUMERIC_LEN;
        case (flaw)
            FLAW_TYPE:    typ  = 8'($urandom_range(3, 255));
            FLAW_KEY_LEN: klen = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(32, 255));
            FLAW_VALUE_LEN: begin
                if (typ == TYPE_STRING) begin
                    vlen = 16'($urandom_range(DEF_MAX_STRING_LENGTH, 65535));
                end else begin
                    vlen = 16'($urandom_range(0, 65535));
                    if (vlen == NUMERIC_LEN)
                        vlen = NUMERIC_LEN + 1'b1;
                end
            end
            default: ;
        endcase
        kbytes = (flaw == FLAW_KEY_LEN) ? 3 : int'(klen);
        vbytes = (flaw == FLAW_VALUE_LEN) ? 3 : int'(vlen);
        blob_bytes.push_back(typ);
        blob_bytes.push_back(klen);
        blob_bytes.push_back(vlen[7:0]);
        blob_bytes.push_back(vlen[15:8]);
        for (i = 0; i < kbytes; i++)
            blob_bytes.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < vbytes; i++)
            blob_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_blob(input int n_rec, input blob_flaw_e flaw,
                                       input int klen_max, input int vlen_max);
        int bad_rec;
        int i;
        blob_bytes.delete();
        bad_rec = (n_rec > 0) ? $urandom_range(0, n_rec - 1) : 0;
        put_header(n_rec, flaw);
        for (i = 0; i < n_rec; i++)
            put_record((i == bad_rec) ? flaw : FLAW_NONE, klen_max, vlen_max);
    endfunction

    // Header only, zero records: accepted with a count of zero
    task automatic test_zero_entry_blob();
        build_blob(0, FLAW_NONE, 1, 0);
        send_blob();
    endtask

    // Float record whose last value byte is also the flagged byte: payload then verdict
    task automatic test_payload_on_last_byte();
        int i;
        blob_bytes.delete();
        put_header(1, FLAW_NONE);
        blob_bytes.push_back(8'(TYPE_FLOAT));
        blob_bytes.push_back(8'd1);
        blob_bytes.push_back(NUMERIC_LEN[7:0]);
        blob_bytes.push_back(8'h00);
        blob_bytes.push_back(8'h00);
        for (i = 0; i < 4; i++)
            blob_bytes.push_back(8'hFF);
        send_blob();
    endtask

    // Bad first magic byte that is also the flagged byte
    task automatic test_bad_magic_single_byte();
        blob_bytes.delete();
        blob_bytes.push_back(8'h00);
        send_blob();
    endtask

    // Full table of small records, each with a one-byte key
    task automatic test_full_table();
        build_blob(DEF_MAX_ENTRIES, FLAW_NONE, 1, 1);
        send_blob();
        wait_for_results();
    endtask

    // Mostly well-formed blobs with random content, the rest broken, cut short or noise
    task automatic test_random_blobs(input int n_bytes, input bit tx_gaps, input bit rx_gaps);
        int         start;
        int         sel;
        int         cut;
        int         i;
        blob_flaw_e flaw;
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        start   = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                if ($urandom_range(0, 3) == 0)
                    build_blob($urandom_range(1, 3), FLAW_NONE, DEF_MAX_KEY_LENGTH - 1,
                               DEF_MAX_STRING_LENGTH - 1);
                else
                    build_blob($urandom_range(0, 5), FLAW_NONE, 6, 8);
                // Trailing bytes after the last record
                if ($urandom_range(0, 4) == 0) begin
                    cut = $urandom_range(1, 6);
                    for (i = 0; i < cut; i++)
                        blob_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end else if (sel < 72) begin
                build_blob($urandom_range(1, 4), FLAW_NONE, 6, 8);
                cut = $urandom_range(1, blob_bytes.size() - 1);
                for (i = 0; i < cut; i++)
                    void'(blob_bytes.pop_back());
            end else if (sel < 92) begin
                flaw = blob_flaw_e'($urandom_range(FLAW_MAGIC, FLAW_VALUE_LEN));
                build_blob($urandom_range(1, 3), flaw, 6, 8);
            end else begin
                blob_bytes.delete();
                cut = $urandom_range(1, 16);
                for (i = 0; i < cut; i++)
                    blob_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_blob();
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        clear_parse_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_entry_blob();
        test_payload_on_last_byte();
        test_bad_magic_single_byte();
        wait_for_results();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_full_table();
        test_random_blobs(150, 1'b1, 1'b1);
        test_random_blobs(150, 1'b0, 1'b1);
        test_random_blobs(150, 1'b1, 1'b0);
        test_random_blobs(150, 1'b0, 1'b0);
        test_random_blobs(150, 1'b1, 1'b1);

        $display("Sent %0d bytes in %0d blobs: %0d accepted, %0d rejected",
                 bytes_sent, blobs_sent, blobs_accepted, blobs_rejected);
        $display("Checked %0d results with %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pbrp_pkg.sv
hw/rtl/pbrp_parser.sv
hw/rtl/pbrp_fifo.sv
hw/rtl/prefs_blob_record_parser.sv
tb/prefs_blob_record_parser_tb.sv
